@@ design/tbl_pkg.sv @@
// Shared types and constants for the per-client token bucket limiter.
`default_nettype none
package tbl_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [31:0] OneToken = 32'h0001_0000;

  typedef enum logic [1:0] {
    OpRequest = 2'd0,
    OpCleanup = 2'd1,
    OpStats   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegEnable   = 3'd0,
    RegRate     = 3'd1,
    RegBurst    = 3'd2,
    RegMaxIdle  = 3'd3,
    RegInterval = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] client_addr;
    logic [47:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic        table_full;
    logic [31:0] total_requests;
    logic [31:0] blocked_requests;
    logic [6:0]  active_clients;
  } rsp_t;

  typedef struct packed {
    logic        limiter_enabled;
    logic [31:0] refill_rate;
    logic [15:0] burst_tokens;
    logic [47:0] max_idle_ticks;
    logic [47:0] cleanup_interval;
  } cfg_t;
endpackage
`default_nettype wire

@@ design/tbl_if.sv @@
// Valid/ready channel carrying one limiter word.
`default_nettype none
interface tbl_req_if;
  logic          valid;
  logic          ready;
  tbl_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbl_rsp_if;
  logic          valid;
  logic          ready;
  tbl_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/tbl_cfg.sv @@
// APB register file for the limiter configuration.
`default_nettype none
module tbl_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output tbl_pkg::cfg_t     cfg_o
);
  tbl_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        tbl_pkg::RegEnable:   cfg_d.limiter_enabled  = pwdata[0];
        tbl_pkg::RegRate:     cfg_d.refill_rate      = pwdata[31:0];
        tbl_pkg::RegBurst:    cfg_d.burst_tokens     = pwdata[15:0];
        tbl_pkg::RegMaxIdle:  cfg_d.max_idle_ticks   = pwdata[47:0];
        tbl_pkg::RegInterval: cfg_d.cleanup_interval = pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tbl_pkg::RegEnable:   prdata = {63'd0, cfg_q.limiter_enabled};
      tbl_pkg::RegRate:     prdata = {32'd0, cfg_q.refill_rate};
      tbl_pkg::RegBurst:    prdata = {48'd0, cfg_q.burst_tokens};
      tbl_pkg::RegMaxIdle:  prdata = {16'd0, cfg_q.max_idle_ticks};
      tbl_pkg::RegInterval: prdata = {16'd0, cfg_q.cleanup_interval};
      default:              prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limiter_enabled  <= 1'b1;
      cfg_q.refill_rate      <= 32'd65536;
      cfg_q.burst_tokens     <= 16'd100;
      cfg_q.max_idle_ticks   <= 48'd300;
      cfg_q.cleanup_interval <= 48'd60;
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule
`default_nettype wire

@@ design/per_client_token_bucket_limiter.sv @@
// Per-client token bucket limiter: top level, sequencer and entry table.
// One word in, one word out. A request scans the 64-entry table one entry per
// cycle through a single memory read port; for a known client it then refills
// the bucket (two 16x32 partial products, add/saturate, write back). A due
// cleanup walks all 64 entries, one per cycle. Statistics, unused ops,
// disabled ops and cleanups not due go straight to the result. The block
// takes no new word until the result word has been taken. Configuration is
// by APB at 8-byte spacing; write it only while the block is idle.
`default_nettype none
module per_client_token_bucket_limiter (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    psel,
  input  wire logic    penable,
  input  wire logic    pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  tbl_req_if.sink      req,
  tbl_rsp_if.source    rsp
);
  localparam int unsigned IdxW = tbl_pkg::IdxW;
  localparam int unsigned CntW = tbl_pkg::CntW;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StScan  = 9'b000000010,
    StRead  = 9'b000000100,
    StMulLo = 9'b000001000,
    StMulHi = 9'b000010000,
    StSum   = 9'b000100000,
    StSweep = 9'b001000000,
    StTail  = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  tbl_pkg::cfg_t cfg;
  tbl_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // entry memory, one read port (registered) and one write port
  logic [31:0] key_mem [tbl_pkg::TableEntries];
  logic [31:0] tok_mem [tbl_pkg::TableEntries];
  logic [47:0] ts_mem  [tbl_pkg::TableEntries];
  logic [tbl_pkg::TableEntries-1:0] valid_q, valid_d;

  state_e state_q, state_d;
  tbl_pkg::req_t cur_q;
  logic [CntW-1:0] ptr_q, ptr_d;     // issued read address
  logic [CntW-1:0] rptr_q;           // address of data in rd_*
  logic            rd_v_q;
  logic [31:0] rd_key_q, rd_tok_q;
  logic [47:0] rd_ts_q;
  logic        hit_q, hit_d, free_v_q, free_v_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [31:0] req_cnt_q, req_cnt_d, blk_cnt_q, blk_cnt_d;
  logic [CntW-1:0] vcnt_q, vcnt_d;
  logic [47:0] last_clean_q, last_clean_d;
  logic [47:0] elapsed_q, elapsed_d;
  logic [31:0] tok_q, tok_d;
  logic [48:0] prod_q, prod_d;
  logic        sat_q, sat_d;
  logic        allowed_q, allowed_d, full_q, full_d;

  logic        we;
  logic [IdxW-1:0] waddr;
  logic [31:0] wkey, wtok;
  logic [47:0] wts;
  logic        re;
  logic [IdxW-1:0] raddr;

  logic [47:0] cap;
  logic [47:0] hi_prod;
  logic [48:0] sum49;
  logic [31:0] refilled;

  assign cap = {16'd0, cfg.burst_tokens, 16'd0};
  assign req.ready = (state_q == StIdle);
  assign rsp.valid = (state_q == StOut);
  assign rsp.data.allowed = allowed_q;
  assign rsp.data.table_full = full_q;
  assign rsp.data.total_requests = req_cnt_q;
  assign rsp.data.blocked_requests = blk_cnt_q;
  assign rsp.data.active_clients = 7'(vcnt_q);

  // product in two halves: lo = elapsed[15:0]*rate, hi = elapsed[31:16]*rate.
  // a hi half past 32 bits already exceeds any capacity once shifted, so it
  // saturates; otherwise both halves stay below 2^48
  always_comb begin
    hi_prod  = {32'd0, elapsed_q[31:16]} * {16'd0, cfg.refill_rate};
    sum49    = {17'd0, tok_q} + prod_q;
    refilled = (sat_q || sum49 >= {1'b0, cap}) ? cap[31:0] : sum49[31:0];
  end

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q; hit_d = hit_q; hit_idx_d = hit_idx_q;
    free_v_d = free_v_q; free_idx_d = free_idx_q;
    req_cnt_d = req_cnt_q; blk_cnt_d = blk_cnt_q; vcnt_d = vcnt_q;
    last_clean_d = last_clean_q; elapsed_d = elapsed_q; tok_d = tok_q;
    prod_d = prod_q; sat_d = sat_q; allowed_d = allowed_q; full_d = full_q;
    valid_d = valid_q;
    we = 1'b0; waddr = hit_idx_q; wkey = cur_q.client_addr;
    wtok = tok_q; wts = cur_q.now_ticks;
    re = 1'b0; raddr = ptr_q[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (req.valid) begin
          allowed_d = 1'b0; full_d = 1'b0;
          hit_d = 1'b0; free_v_d = 1'b0; ptr_d = '0;
          state_d = StOut;
          if (req.data.op == tbl_pkg::OpRequest) begin
            if (!cfg.limiter_enabled) allowed_d = 1'b1;
            else begin
              req_cnt_d = req_cnt_q + 32'd1;
              state_d = StScan;
            end
          end else if (req.data.op == tbl_pkg::OpCleanup && cfg.limiter_enabled &&
                       ((req.data.now_ticks - last_clean_q) >= cfg.cleanup_interval)) begin
            last_clean_d = req.data.now_ticks;
            state_d = StSweep;
          end
        end
      end
      StScan, StSweep: begin
        if (ptr_q < CntW'(tbl_pkg::TableEntries)) begin
          re = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end
        if (rd_v_q) begin
          if (state_q == StScan) begin
            if (valid_q[rptr_q[IdxW-1:0]]) begin
              if (!hit_q && rd_key_q == cur_q.client_addr) begin
                hit_d = 1'b1; hit_idx_d = rptr_q[IdxW-1:0];
                elapsed_d = cur_q.now_ticks - rd_ts_q;
                tok_d = rd_tok_q;
              end
            end else if (!free_v_q) begin
              free_v_d = 1'b1; free_idx_d = rptr_q[IdxW-1:0];
            end
          end else if (valid_q[rptr_q[IdxW-1:0]] &&
                       (cur_q.now_ticks - rd_ts_q) > cfg.max_idle_ticks) begin
            valid_d[rptr_q[IdxW-1:0]] = 1'b0;
            vcnt_d = vcnt_d - 1'b1;
          end
          if (rptr_q == CntW'(tbl_pkg::TableEntries - 1))
            state_d = (state_q == StScan) ? StRead : StOut;
        end
      end
      StRead: begin
        allowed_d = 1'b1;
        if (!hit_q) begin
          state_d = StOut;
          if (!free_v_q) full_d = 1'b1;
          else begin
            we = 1'b1; waddr = free_idx_q;
            wtok = (cfg.burst_tokens != 16'd0) ? cap[31:0] - tbl_pkg::OneToken : 32'd0;
            valid_d[free_idx_q] = 1'b1;
            vcnt_d = vcnt_q + 1'b1;
          end
        end else begin
          sat_d = (cfg.refill_rate != 32'd0) && (elapsed_q >= cap);
          prod_d = {1'b0, {32'd0, elapsed_q[15:0]} * {16'd0, cfg.refill_rate}};
          state_d = StMulLo;
        end
      end
      StMulLo: begin
        prod_d = prod_q + {1'b0, hi_prod[31:0], 16'd0};
        sat_d = sat_q | (hi_prod[47:32] != 16'd0);
        state_d = StMulHi;
      end
      StMulHi: begin
        tok_d = refilled;
        state_d = StSum;
      end
      StSum: begin
        we = 1'b1;
        if (tok_q >= tbl_pkg::OneToken) wtok = tok_q - tbl_pkg::OneToken;
        else begin
          allowed_d = 1'b0;
          blk_cnt_d = blk_cnt_q + 32'd1;
        end
        state_d = StOut;
      end
      StTail: state_d = StOut;
      StOut: if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      tok_mem[waddr] <= wtok;
      ts_mem[waddr]  <= wts;
    end
    if (re) begin
      rd_key_q <= key_mem[raddr];
      rd_tok_q <= tok_mem[raddr];
      rd_ts_q  <= ts_mem[raddr];
    end
    rptr_q <= ptr_q;
    if (req.valid && req.ready) cur_q <= req.data;
    hit_idx_q <= hit_idx_d; free_idx_q <= free_idx_d;
    elapsed_q <= elapsed_d; tok_q <= tok_d; prod_q <= prod_d; sat_q <= sat_d;
    allowed_q <= allowed_d; full_q <= full_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ptr_q <= '0; rd_v_q <= 1'b0;
      hit_q <= 1'b0; free_v_q <= 1'b0;
      valid_q <= '0;
      req_cnt_q <= '0; blk_cnt_q <= '0; vcnt_q <= '0; last_clean_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d; rd_v_q <= re;
      hit_q <= hit_d; free_v_q <= free_v_d;
      valid_q <= valid_d;
      req_cnt_q <= req_cnt_d; blk_cnt_q <= blk_cnt_d; vcnt_q <= vcnt_d;
      last_clean_q <= last_clean_d;
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for the per-client token bucket limiter: request/cleanup/stats checks.
`timescale 1ns / 1ps
module testbench;
  import tbl_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  tbl_req_if req_ch ();
  tbl_rsp_if rsp_ch ();

  per_client_token_bucket_limiter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // limiter model state
  cfg_t        cfg;
  logic        ent_valid [TableEntries];
  logic [31:0] ent_key [TableEntries];
  logic [31:0] ent_tokens [TableEntries];
  logic [47:0] ent_last [TableEntries];
  logic [31:0] req_count, blk_count;
  logic [6:0]  live_count;
  logic [47:0] last_sweep;

  req_t pending_words [$];
  rsp_t expected_rsps [$];
  int   errors = 0;
  int   send_idle_pct = 0, recv_stall_pct = 0;
  bit   recv_hold = 1'b0;
  bit   all_queued = 1'b0;
  longint cycles = 0;

  function automatic rsp_t predict_limiter(req_t w);
    rsp_t r;
    logic [63:0] cap, tok, elapsed;
    int hit, free_slot;
    r = '0;
    if (w.op == OpRequest) begin
      r.allowed = 1'b1;
      if (cfg.limiter_enabled) begin
        cap = {32'd0, cfg.burst_tokens, 16'd0};
        hit = -1;
        free_slot = -1;
        req_count++;
        for (int i = 0; i < TableEntries; i++) begin
          if (ent_valid[i]) begin
            if (hit < 0 && ent_key[i] == w.client_addr) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit < 0) begin
          if (free_slot < 0) begin
            r.table_full = 1'b1;
          end else begin
            ent_valid[free_slot] = 1'b1;
            ent_key[free_slot] = w.client_addr;
            ent_tokens[free_slot] = (cap >= 64'h10000) ? 32'(cap - 64'h10000) : 32'd0;
            ent_last[free_slot] = w.now_ticks;
            live_count++;
          end
        end else begin
          elapsed = {16'd0, 48'(w.now_ticks - ent_last[hit])};
          tok = {32'd0, ent_tokens[hit]};
          if (cfg.refill_rate != 0 && elapsed >= cap) tok = cap;
          else begin
            tok = tok + elapsed * {32'd0, cfg.refill_rate};
            if (tok > cap) tok = cap;
          end
          ent_last[hit] = w.now_ticks;
          if (tok >= 64'h10000) begin
            ent_tokens[hit] = 32'(tok - 64'h10000);
          end else begin
            ent_tokens[hit] = 32'(tok);
            blk_count++;
            r.allowed = 1'b0;
          end
        end
      end
    end else if (w.op == OpCleanup && cfg.limiter_enabled) begin
      if (48'(w.now_ticks - last_sweep) >= cfg.cleanup_interval) begin
        for (int i = 0; i < TableEntries; i++)
          if (ent_valid[i] && 48'(w.now_ticks - ent_last[i]) > cfg.max_idle_ticks) begin
            ent_valid[i] = 1'b0;
            live_count--;
          end
        last_sweep = w.now_ticks;
      end
    end
    r.total_requests = req_count;
    r.blocked_requests = blk_count;
    r.active_clients = live_count;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_words.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check on result
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got, want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      cycles++;
      if (req_ch.valid && req_ch.ready)
        expected_rsps.push_back(predict_limiter(req_ch.data));
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $time, got);
        end else begin
          want = expected_rsps.pop_front();
          if (got.allowed !== want.allowed || got.table_full !== want.table_full ||
              got.total_requests !== want.total_requests ||
              got.blocked_requests !== want.blocked_requests ||
              got.active_clients !== want.active_clients) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
          end
        end
      end
      rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off; the calling process waits until it ends
  task automatic hold_receiver(int n);
    recv_hold = 1'b1;
    repeat (n) @(posedge clk_i);
    recv_hold = 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx) << 3; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegEnable:   cfg.limiter_enabled = val[0];
      RegRate:     cfg.refill_rate = val[31:0];
      RegBurst:    cfg.burst_tokens = val[15:0];
      RegMaxIdle:  cfg.max_idle_ticks = val[47:0];
      RegInterval: cfg.cleanup_interval = val[47:0];
      default: ;
    endcase
  endtask

  function automatic void add_word(op_e op, logic [31:0] addr, logic [47:0] now);
    req_t w;
    w.op = op;
    w.client_addr = addr;
    w.now_ticks = now;
    pending_words.push_back(w);
  endfunction

  logic [47:0] clock_now = '0;
  logic [31:0] clients [16];

  // mostly requests from a small client pool over advancing time, with rare random jumps
  task automatic random_burst(int n);
    int pick;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      clock_now = clock_now + 48'($urandom_range(($urandom_range(3) == 0) ? 400 : 3));
      if ($urandom_range(99) == 0) clock_now = 48'({$urandom, $urandom});
      pick = $urandom_range(99);
      a = ($urandom_range(4) == 0) ? $urandom : clients[$urandom_range(15)];
      if (pick < 80) add_word(OpRequest, a, clock_now);
      else if (pick < 90) add_word(OpCleanup, $urandom, clock_now);
      else if (pick < 97) add_word(OpStats, $urandom, clock_now);
      else add_word(OpNone, $urandom, clock_now);
    end
  endtask

  initial begin
    cfg.limiter_enabled = 1'b1;
    cfg.refill_rate = 32'd65536;
    cfg.burst_tokens = 16'd100;
    cfg.max_idle_ticks = 48'd300;
    cfg.cleanup_interval = 48'd60;
    for (int i = 0; i < TableEntries; i++) begin
      ent_valid[i] = 1'b0; ent_key[i] = '0; ent_tokens[i] = '0; ent_last[i] = '0;
    end
    req_count = '0; blk_count = '0; live_count = '0; last_sweep = '0;
    for (int i = 0; i < 16; i++) clients[i] = $urandom;
    clients[0] = 32'd0;
    clients[1] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: small burst, drain a bucket, stats, unused op, extremes
    apb_write(RegBurst, 64'd2);
    apb_write(RegRate, 64'd0);
    add_word(OpRequest, 32'h0, 48'd0);
    add_word(OpRequest, 32'h0, 48'd1);
    add_word(OpRequest, 32'h0, 48'd2);
    add_word(OpRequest, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_word(OpRequest, 32'hFFFF_FFFF, 48'd5);
    add_word(OpStats, 32'h1234_5678, 48'd6);
    add_word(OpNone, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_word(OpCleanup, 32'h0, 48'd10);
    add_word(OpCleanup, 32'h0, 48'd1000);
    drain();
    // zero burst, disabled ops
    apb_write(RegBurst, 64'd0);
    add_word(OpRequest, 32'hA5A5_5A5A, 48'd2000);
    add_word(OpRequest, 32'hA5A5_5A5A, 48'd3000);
    drain();
    apb_write(RegEnable, 64'd0);
    add_word(OpRequest, 32'h5555_AAAA, 48'd3001);
    add_word(OpCleanup, 32'h0, 48'hFFFF_0000_0000);
    drain();
    apb_write(RegEnable, 64'd1);
    apb_write(RegBurst, 64'd65535);
    apb_write(RegRate, 64'hFFFF_FFFF);
    apb_write(RegMaxIdle, 64'hFFFF_FFFF_FFFF);
    apb_write(RegInterval, 64'd0);
    add_word(OpRequest, 32'h0, 48'd3005);
    // fill the table past full
    for (int i = 0; i < 66; i++) add_word(OpRequest, 32'h100 + i, 48'd3010 + i);
    add_word(OpCleanup, 32'h0, 48'd3100);
    drain();
    // lowered burst then refill; max idle zero sweep clears all
    apb_write(RegBurst, 64'd3);
    apb_write(RegMaxIdle, 64'd0);
    add_word(OpRequest, 32'h100, 48'd3200);
    add_word(OpCleanup, 32'h0, 48'd3300);
    add_word(OpCleanup, 32'h0, 48'hFFFF_FFFF_FFFF);
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      apb_write(RegBurst, (ph == 7) ? 64'd65535 : 64'($urandom_range(1, 6)));
      apb_write(RegRate, (ph == 6) ? 64'd0 : 64'($urandom_range(0, 32'h3_0000)));
      apb_write(RegMaxIdle, 64'($urandom_range(0, 1200)));
      apb_write(RegInterval, 64'($urandom_range(0, 200)));
      apb_write(RegEnable, (ph == 3) ? 64'd0 : 64'd1);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 88; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 88; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      random_burst(200);
      if (ph == 0) hold_receiver(600);
      drain();
    end
    all_queued = 1'b1;
  end

  initial begin
    wait (all_queued);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("PASS per_client_token_bucket_limiter");
    else $display("FAIL per_client_token_bucket_limiter");
    $finish;
  end

  initial begin
    wait (cycles > 900000);
    $display("FAIL per_client_token_bucket_limiter");
    $finish;
  end
endmodule
